/* rtl/iida_pkg.sv */
// ----------------------------------------------------------------------------
// iida_pkg: shared types and constants of the indexed insert/delete array
// Request and response transfers, action and status codes, default sizes.
// ----------------------------------------------------------------------------
package iida_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEPTH_DEF  = 64;
    localparam int ELEM_W_DEF = 32;

    // Fixed field widths of the request and response transfers
    localparam int ACT_W  = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND     = 3'd0,
        ACT_INSERT     = 3'd1,
        ACT_REMOVE_END = 3'd2,
        ACT_REMOVE     = 3'd3,
        ACT_READ       = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] count;
        logic [CNT_OUT_W-1:0] capacity_now;
        logic [VAL_W-1:0]     read_value;
    } rsp_t;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic ins;  // cells above the target take the left neighbour
        logic rem;  // cells at and above the target take the right neighbour
        logic rd;   // target cell drives its data onto the read bus
    } cell_op_t;

endpackage

/* rtl/iida_cell.sv */
// ----------------------------------------------------------------------------
// iida_cell: one storage cell of the shifting chain
// Holds one entry; shifts up on insert, down on remove, drives reads.
// ----------------------------------------------------------------------------
module iida_cell #(
    parameter int INDEX  = 0,
    parameter int ELEM_W = 32,
    parameter int AT_W   = 7
) (
    input  logic                  clk,
    input  iida_pkg::cell_op_t    op,
    input  logic [AT_W-1:0]       at,
    input  logic [ELEM_W-1:0]     value_in,
    input  logic [ELEM_W-1:0]     left,
    input  logic [ELEM_W-1:0]     right,
    output logic [ELEM_W-1:0]     data,
    output logic [ELEM_W-1:0]     rd_data
);
    import iida_pkg::*;

    localparam logic [AT_W-1:0] MY_IDX = AT_W'(INDEX);

    logic [ELEM_W-1:0] data_reg;
    logic [ELEM_W-1:0] data_next;
    logic              is_target;
    logic              above_target;

    assign is_target    = (MY_IDX == at);
    assign above_target = (MY_IDX > at);

    // Pick the new content from the neighbours or the incoming value
    always_comb
    begin
        data_next = data_reg;
        if (op.ins)
        begin
            if (above_target)
                data_next = left;
            else if (is_target)
                data_next = value_in;
        end
        else if (op.rem)
        begin
            if (above_target || is_target)
                data_next = right;
        end
    end

    // Hold or shift the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (op.rd && is_target) ? data_reg : '0;

endmodule

/* rtl/iida_ctrl.sv */
// ----------------------------------------------------------------------------
// iida_ctrl: action decode, count and capacity
// Checks each request, drives the cell chain and tracks count and capacity.
// ----------------------------------------------------------------------------
module iida_ctrl #(
    parameter int DEPTH = 64,
    parameter int CNT_W = 7,
    parameter int AT_W  = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          exec,
    input  logic [iida_pkg::ACT_W-1:0]    action,
    input  logic [iida_pkg::POS_W-1:0]    position,
    output iida_pkg::cell_op_t            op,
    output logic [AT_W-1:0]               at,
    output logic [iida_pkg::STAT_W-1:0]   status,
    output logic [CNT_W-1:0]              count_next,
    output logic [CNT_W-1:0]              cap_next
);
    import iida_pkg::*;

    localparam logic [AT_W-1:0]  DEPTH_AT  = AT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_DBL = (CNT_W+1)'(DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] cap_reg;
    logic [AT_W-1:0]  pos_ext;
    logic [AT_W-1:0]  cnt_ext;
    logic [CNT_W:0]   cap_dbl;
    logic [CNT_W-1:0] cnt_dec;

    assign pos_ext = AT_W'(position);
    assign cnt_ext = AT_W'(count_reg);
    assign cap_dbl = {cap_reg, 1'b0};
    assign cnt_dec = count_reg - CNT_W'(1);

    // Decode the request and work out the new count and capacity
    always_comb
    begin
        op         = '0;
        at         = pos_ext;
        status     = ST_OK;
        count_next = count_reg;
        cap_next   = cap_reg;
        if (exec)
        begin
            unique case (action)
                ACT_APPEND, ACT_INSERT:
                begin
                    if (action == ACT_APPEND)
                        at = cnt_ext;
                    if (at > cnt_ext)
                        status = ST_BAD_INDEX;
                    else if (cnt_ext >= DEPTH_AT)
                        status = ST_FULL;
                    else
                    begin
                        op.ins     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg == cap_reg)
                            cap_next = (cap_dbl > DEPTH_DBL) ? CNT_W'(DEPTH)
                                                             : cap_dbl[CNT_W-1:0];
                    end
                end
                ACT_REMOVE_END, ACT_REMOVE:
                begin
                    if (action == ACT_REMOVE_END)
                        at = AT_W'(cnt_dec);
                    if (count_reg == '0)
                        status = ST_EMPTY;
                    else if (at >= cnt_ext)
                        status = ST_BAD_INDEX;
                    else
                    begin
                        op.rem     = 1'b1;
                        count_next = cnt_dec;
                        if ((cnt_dec <= (cap_reg >> 2)) && (cap_reg > CNT_W'(1)))
                            cap_next = cap_reg >> 1;
                    end
                end
                ACT_READ:
                begin
                    if (pos_ext >= cnt_ext)
                        status = ST_BAD_INDEX;
                    else
                        op.rd = 1'b1;
                end
                default:
                begin
                    // unknown action: report ok and leave state alone
                end
            endcase
        end
    end

    // Advance count and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CNT_W'(1);
        end
        else
        begin
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    // Count never runs past the hard limit or the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(DEPTH)) && (count_reg <= cap_reg))
        else $error("count beyond capacity or hard limit");

    // Capacity stays between one and the hard limit
    a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cap_reg >= CNT_W'(1)) && (cap_reg <= CNT_W'(DEPTH)))
        else $error("capacity out of range");

    // A rejected request changes nothing
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (status != ST_OK)) |=>
            ($stable(count_reg) && $stable(cap_reg)))
        else $error("rejected request altered state");

    // Shifts and reads only on an accepted request, one kind at a time
    a_op_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({op.ins, op.rem, op.rd}) && ((op == '0) || (status == ST_OK)))
        else $error("conflicting cell operations");

endmodule

/* rtl/indexed_insert_delete_array.sv */
// ----------------------------------------------------------------------------
// indexed_insert_delete_array: ordered store with growing/shrinking capacity
// Append, insert, remove last, remove at index and read over a cell chain.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Payload   Direction
//  request   start / busy     req       in
//  result    done (strobe)    rsp       out
//
//  A request is taken at the first edge with start high; busy stays low, so a
//  new request may follow in every cycle. Its result shows on rsp with done
//  after the transfer has passed one request stage and one execute stage; every
//  cell shifts locally in the execute cycle, so throughput is one per clock.
//  Reset gives an empty store with capacity one; entries themselves are not
//  cleared. The receiver cannot stall: each result is valid for one cycle.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array #(
    parameter int DEPTH         = iida_pkg::DEPTH_DEF,
    parameter int ELEMENT_WIDTH = iida_pkg::ELEM_W_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  iida_pkg::req_t req,
    output logic           done,
    output iida_pkg::rsp_t rsp
);
    import iida_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WIDE_W = (ELEMENT_WIDTH > VAL_W) ? ELEMENT_WIDTH : VAL_W;

    req_t              req_reg;
    logic              exec_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              done_reg;

    cell_op_t          op;
    logic [AT_W-1:0]   at;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  cap_next;

    logic [WIDE_W-1:0]        value_wide;
    logic [ELEMENT_WIDTH-1:0] elem_in;
    logic [ELEMENT_WIDTH-1:0] cell_data [DEPTH];
    logic [ELEMENT_WIDTH-1:0] cell_rd   [DEPTH];
    logic [ELEMENT_WIDTH-1:0] rd_bus;
    logic [WIDE_W-1:0]        rd_wide;

    // Every request transfer completes at once
    assign busy = 1'b0;

    // Capture the request transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exec_reg <= 1'b0;
        else
            exec_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= req;
    end

    iida_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .AT_W  (AT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .exec       (exec_reg),
        .action     (req_reg.action),
        .position   (req_reg.position),
        .op         (op),
        .at         (at),
        .status     (status),
        .count_next (count_next),
        .cap_next   (cap_next)
    );

    // Fit the request value to the element width
    assign value_wide = WIDE_W'(req_reg.value);
    assign elem_in    = value_wide[ELEMENT_WIDTH-1:0];

    // Row of cells, each linked to its two neighbours
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left_in;
        logic [ELEMENT_WIDTH-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_inner_l
            assign left_in = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_inner_r
            assign right_in = cell_data[i+1];
        end

        iida_cell #(
            .INDEX  (i),
            .ELEM_W (ELEMENT_WIDTH),
            .AT_W   (AT_W)
        ) u_cell (
            .clk      (clk),
            .op       (op),
            .at       (at),
            .value_in (elem_in),
            .left     (left_in),
            .right    (right_in),
            .data     (cell_data[i]),
            .rd_data  (cell_rd[i])
        );
    end

    // Merge the read outputs; at most one cell drives
    always_comb
    begin
        rd_bus = '0;
        for (int k = 0; k < DEPTH; k++)
            rd_bus = rd_bus | cell_rd[k];
    end

    assign rd_wide = WIDE_W'(rd_bus);

    // Assemble the result
    always_comb
    begin
        rsp_next.status       = status;
        rsp_next.count        = CNT_OUT_W'(count_next);
        rsp_next.capacity_now = CNT_OUT_W'(cap_next);
        rsp_next.read_value   = rd_wide[VAL_W-1:0];
    end

    // Drive the result strobe for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= exec_reg;
    end

    always_ff @(posedge clk)
    begin
        if (exec_reg)
            rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Each result follows exactly one request transfer through the request and execute stages
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a request");

    // A transfer always yields a result
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("request without a result");

    // Read data only appears for a good read
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != ST_OK) |-> (rsp.read_value == '0))
        else $error("read data on a rejected request");

endmodule
